[hw/rtl/pbds_pkg.sv]
// Shared types and constants for the drop-tail packet buffer scheduler.
package pbds_pkg;

    localparam int CAP_W = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] ADDR_CAPACITY = 2'd0;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic [31:0] arr_time;
        logic [15:0] svc_time;
    } t_in_item;

    typedef struct packed {
        logic        dropped;
        logic [31:0] srv_start;
    } t_out_item;

endpackage

[hw/rtl/packet_buffer_drop_tail_scheduler_unit.sv]
// Top level of the drop-tail packet buffer scheduler.
// Flow: a push is queued in the front end, the engine takes it into its check
// state, retires expired entries of the finish-time ring one at a time, and then
// registers it once the output register is free; one packet is handled at a time.
// Reset: synchronous active low; queues empty, capacity 64, ring contents kept.
module packet_buffer_drop_tail_scheduler_unit #(
    parameter int MAX_DEPTH = 64,
    parameter int TIME_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  pbds_pkg::t_in_item                 i_in_item,
    output logic                               empty,
    input  logic                               pop,
    output pbds_pkg::t_out_item                o_out_item,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pbds_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [pbds_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [pbds_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import pbds_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             fe_vld;
    t_in_item         fe_item;
    logic             fe_take;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_CAPACITY);
    assign prdata = (paddr == ADDR_CAPACITY) ? CFG_DATA_W'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    pbds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_in_item),
        .o_full  (full),
        .o_vld   (fe_vld),
        .o_item  (fe_item),
        .i_take  (fe_take)
    );

    pbds_engine #(
        .MAX_DEPTH (MAX_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (fe_vld),
        .i_item     (fe_item),
        .o_take     (fe_take),
        .i_capacity (r_capacity),
        .o_empty    (empty),
        .o_item     (o_out_item),
        .i_pop      (pop)
    );

endmodule

[hw/rtl/pbds_front.sv]
// Front end: two-entry input queue that takes packet transactions.
module pbds_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pbds_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_vld,
    output pbds_pkg::t_in_item o_item,
    input  logic              i_take
);
    import pbds_pkg::*;

    t_in_item   r_slot [2];
    logic       r_wr_ptr;
    logic       n_wr_ptr;
    logic       r_rd_ptr;
    logic       n_rd_ptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       push_ok;
    logic       take_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_vld   = (r_cnt != 2'd0);
    assign o_item  = r_slot[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign take_ok = i_take && o_vld;

    always_comb begin
        n_wr_ptr = push_ok ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = take_ok ? !r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, push_ok} - {1'b0, take_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

[hw/rtl/pbds_engine.sv]
// Back end: finish-time ring, retire sequencer and result register.
module pbds_engine #(
    parameter int MAX_DEPTH = 64,
    parameter int TIME_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  pbds_pkg::t_in_item           i_item,
    output logic                         o_take,
    input  logic [pbds_pkg::CAP_W-1:0]   i_capacity,
    output logic                         o_empty,
    output pbds_pkg::t_out_item          o_item,
    input  logic                         i_pop
);
    import pbds_pkg::*;

    localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int SUM_W = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_CHECK = 1'b1;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic [TIME_BITS-1:0] r_ring [MAX_DEPTH];
    logic [TIME_BITS-1:0] r_rd;

    logic                 r_state;
    logic                 n_state;
    logic [AW-1:0]        r_head;
    logic [AW-1:0]        n_head;
    logic [AW-1:0]        r_tail;
    logic [AW-1:0]        n_tail;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [TIME_BITS-1:0] r_last;
    logic [TIME_BITS-1:0] n_last;
    logic [TIME_BITS-1:0] r_arr;
    logic [TIME_BITS-1:0] n_arr;
    logic [15:0]          r_svc;
    logic [15:0]          n_svc;
    logic                 r_out_vld;
    logic                 n_out_vld;
    t_out_item            r_out;
    t_out_item            n_out;

    logic [AW-1:0]        head_adv;
    logic [AW-1:0]        tail_adv;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic                 drop;
    logic [TIME_BITS-1:0] start;
    logic [SUM_W-1:0]     sum;
    logic [TIME_BITS-1:0] finish;

    assign head_adv = (r_head == AW'(MAX_DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign tail_adv = (r_tail == AW'(MAX_DEPTH - 1)) ? '0 : r_tail + AW'(1);
    assign drop     = (CMP_W'(r_count) >= CMP_W'(i_capacity))
                   || (CMP_W'(r_count) >= CMP_W'(MAX_DEPTH));
    assign start    = (r_count == '0) ? r_arr : r_last;
    assign sum      = SUM_W'(start) + SUM_W'(r_svc);
    assign finish   = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(sum);

    assign o_empty  = !r_out_vld;
    assign o_item   = r_out;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_last    = r_last;
        n_arr     = r_arr;
        n_svc     = r_svc;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_pop;
        rd_addr   = r_head;
        wr_en     = 1'b0;
        o_take    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_vld) begin
                    o_take  = 1'b1;
                    n_arr   = TIME_BITS'(i_item.arr_time);
                    n_svc   = i_item.svc_time;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if ((r_count != '0) && (r_rd <= r_arr)) begin
                    n_head  = head_adv;
                    n_count = r_count - CNT_W'(1);
                    rd_addr = head_adv;
                end else if (!r_out_vld || i_pop) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                    if (drop) begin
                        n_out.dropped   = 1'b1;
                        n_out.srv_start = '0;
                    end else begin
                        n_out.dropped   = 1'b0;
                        n_out.srv_start = 32'(start);
                        n_last          = finish;
                        wr_en           = 1'b1;
                        n_tail          = tail_adv;
                        n_count         = r_count + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_last    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_last    <= n_last;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_arr <= n_arr;
        r_svc <= n_svc;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[r_tail] <= finish;
        end
        r_rd <= r_ring[rd_addr];
    end

endmodule

[tb/packet_buffer_drop_tail_scheduler_unit_tb.sv]
// Self-checking testbench for the drop-tail packet buffer scheduler unit.
module packet_buffer_drop_tail_scheduler_unit_tb;
    import pbds_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 80;
    localparam logic [6:0]  DEPTH         = 7'd64;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    t_in_item               in_item = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    t_out_item              out_item;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [CFG_DATA_W-1:0]  pwdata = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    logic [31:0]            finish_times [64];
    logic [5:0]             ring_head = '0;
    logic [6:0]             ring_count = '0;
    logic [31:0]            newest_finish = '0;
    logic [6:0]             buffer_limit = CAP_RESET;

    t_out_item              predicted_schedule [$];
    int                     mismatch_count = 0;
    int                     cycle_count = 0;
    int                     pop_hold = 0;
    bit                     no_idle = 1'b0;

    packet_buffer_drop_tail_scheduler_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_out_item schedule_packet(input t_in_item pkt);
        t_out_item   outcome;
        logic [6:0]  limit;
        logic [31:0] start;
        logic [32:0] total;
        logic [5:0]  tail;
        while (ring_count != 0 && finish_times[ring_head] <= pkt.arr_time) begin
            ring_head  = ring_head + 6'd1;
            ring_count = ring_count - 7'd1;
        end
        limit = (buffer_limit > DEPTH) ? DEPTH : buffer_limit;
        if (ring_count >= limit) begin
            outcome.dropped   = 1'b1;
            outcome.srv_start = '0;
            return outcome;
        end
        start         = (ring_count == 0) ? pkt.arr_time : newest_finish;
        total         = {1'b0, start} + {17'd0, pkt.svc_time};
        newest_finish = total[32] ? 32'hFFFF_FFFF : total[31:0];
        tail          = ring_head + ring_count[5:0];
        finish_times[tail] = newest_finish;
        ring_count    = ring_count + 7'd1;
        outcome.dropped   = 1'b0;
        outcome.srv_start = start;
        return outcome;
    endfunction

    task automatic report_mismatch(input string what, input t_out_item want,
                                   input t_out_item got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): dropped exp %0d got %0d, srv_start exp %h got %h",
                     what, want.dropped, got.dropped, want.srv_start, got.srv_start);
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (predicted_schedule.size() == 0) begin
                report_mismatch("unexpected transaction", '0, out_item);
            end else begin
                want = predicted_schedule.pop_front();
                if (out_item.dropped !== want.dropped)
                    report_mismatch("dropped", want, out_item);
                else if (out_item.srv_start !== want.srv_start)
                    report_mismatch("srv_start", want, out_item);
            end
        end
        if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold--;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            pop <= 1'b0;
            pop_hold = $urandom_range(0, 18);
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic send_packet(input logic [31:0] arrival, input logic [15:0] service);
        t_in_item  pkt;
        t_out_item expected;
        int        gap;
        pkt.arr_time = arrival;
        pkt.svc_time = service;
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push    <= 1'b1;
        in_item <= pkt;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        expected = schedule_packet(pkt);
        predicted_schedule.insert(predicted_schedule.size(), expected);
    endtask

    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (predicted_schedule.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [6:0] value);
        logic [CFG_DATA_W-1:0] readback;
        t_out_item             want;
        t_out_item             got;
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= {25'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        buffer_limit = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== {25'd0, value}) begin
            want = '{dropped: 1'b0, srv_start: {25'd0, value}};
            got  = '{dropped: 1'b0, srv_start: readback};
            report_mismatch("capacity readback", want, got);
        end
        @(posedge i_clk);
    endtask

    task automatic test_boundary_times();
        send_packet(32'd0, 16'd0);
        send_packet(32'd0, 16'hFFFF);
        send_packet(32'd10, 16'd1);
        send_packet(32'd5, 16'd7);
        send_packet(32'h0001_0007, 16'd3);
    endtask

    task automatic test_finish_saturation();
        send_packet(32'hFFFF_FFF0, 16'hFFFF);
        send_packet(32'hFFFF_FFFE, 16'd0);
        send_packet(32'hFFFF_FFFF, 16'h8000);
    endtask

    task automatic test_zero_capacity();
        write_capacity(7'd0);
        send_packet(32'hFFFF_FFFF, 16'hFFFF);
        send_packet(32'd0, 16'd0);
    endtask

    task automatic test_capacity_shrink();
        write_capacity(DEPTH);
        repeat (4) send_packet(32'd1000, 16'd100);
        write_capacity(7'd2);
        send_packet(32'd1050, 16'd1);
        send_packet(32'd1250, 16'd9);
        send_packet(32'd1300, 16'd9);
    endtask

    task automatic test_random_traffic(input logic [6:0] capacity, input int unsigned segment,
                                       input int count);
        logic [31:0]  arr;
        logic [15:0]  service;
        int unsigned  step;
        int           run_left;
        bit           heavy;
        write_capacity(capacity);
        arr      = (32'(segment) << 29) | $urandom_range(0, 32'h0FFF_FFFF);
        run_left = 0;
        heavy    = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                heavy    = $urandom_range(0, 1);
                run_left = $urandom_range(10, 80);
            end
            run_left--;
            step = heavy ? $urandom_range(0, 100) : $urandom_range(0, 12000);
            if ($urandom_range(0, 9) == 0)
                service = 16'($urandom());
            else
                service = 16'($urandom_range(0, 1000));
            if ($urandom_range(0, 31) == 0 && arr > 32'd500) begin
                send_packet(arr - $urandom_range(1, 500), service);
            end else begin
                arr = arr + step;
                send_packet(arr, service);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_boundary_times();
        test_finish_saturation();
        test_zero_capacity();
        test_capacity_shrink();
        test_random_traffic(7'd1, 0, 120);
        test_random_traffic(DEPTH, 1, 125);
        test_random_traffic(7'd4, 2, 120);
        test_random_traffic(7'd127, 3, 125);
        test_random_traffic(7'd17, 4, 120);
        test_random_traffic(7'($urandom_range(2, 63)), 5, 120);
        no_idle = 1'b1;
        test_random_traffic(7'd100, 6, 120);
        settle();
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
